// ----- rtl/core/siur_pkg.sv -----
// ----------------------------------------------------------------------------
// siur_pkg
// Shared types, codes and helpers of the segmented image update receiver.
// ----------------------------------------------------------------------------
package siur_pkg;

    // Default geometry of one image block
    localparam int DEF_BLOCK_WORDS        = 64;
    localparam int DEF_WORDS_PER_SEGMENT  = 6;
    localparam int DEF_SEGMENTS_PER_BLOCK = 11;

    // Program words carried by one segment item
    localparam int CARRIED_WORDS = 6;

    localparam logic [31:0] START_MAGIC = 32'h1671_1671;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    // Register reset values
    localparam logic [15:0] APP_BASE_RST      = 16'd0;
    localparam logic [15:0] MAX_BLOCKS_RST    = 16'd128;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;

    // Configuration register indexes
    localparam logic [1:0] CFG_APP_BASE      = 2'd0;
    localparam logic [1:0] CFG_MAX_BLOCKS    = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_SEGMENT  = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_READBACK = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_LATCH   = 3'd0,
        KIND_COMMIT  = 3'd1,
        KIND_ERASE   = 3'd2,
        KIND_REQUEST = 3'd3,
        KIND_VSTART  = 3'd4,
        KIND_SUCCESS = 3'd5,
        KIND_FAIL    = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_RECV   = 2'd1,
        PH_VERIFY = 2'd2
    } phase_t;

    typedef enum logic {
        FR_ACCEPT = 1'b0,
        FR_CRC    = 1'b1
    } fr_state_t;

    // One classified item: the ordered list of results it produces
    typedef struct packed {
        logic                               erase;
        logic [2:0]                         lat_n;
        logic [15:0]                        lat_addr;
        logic [CARRIED_WORDS-1:0][23:0]     words;
        logic                               commit;
        logic                               request;
        logic [15:0]                        blk;
        logic [15:0]                        miss;
        logic                               vstart;
        logic                               finish;
        logic                               pass;
        logic [31:0]                        crc;
    } job_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/siur_front.sv -----
// ----------------------------------------------------------------------------
// siur_front
// Accepts input transactions, keeps the session state and turns each item
// into a job for the result sequencer. Read-back words go through the CRC
// one byte per cycle; the last step of the final word waits for queue room.
// ----------------------------------------------------------------------------
module siur_front #(
    parameter int BLOCK_WORDS        = siur_pkg::DEF_BLOCK_WORDS,
    parameter int WORDS_PER_SEGMENT  = siur_pkg::DEF_WORDS_PER_SEGMENT,
    parameter int SEGMENTS_PER_BLOCK = siur_pkg::DEF_SEGMENTS_PER_BLOCK
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_index,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_tuser,
    input  logic [231:0]        s_tdata,
    input  logic                q_full,
    output logic                q_push,
    output siur_pkg::job_t      q_job
);
    import siur_pkg::*;

    localparam int NCARRY = (WORDS_PER_SEGMENT < CARRIED_WORDS) ?
                            WORDS_PER_SEGMENT : CARRIED_WORDS;
    localparam int VCNT_W = 16 + $clog2(BLOCK_WORDS);

    // Configuration
    logic [15:0] app_base_reg, max_blocks_reg, timeout_reg;

    // Session state
    fr_state_t                      state_reg, state_next;
    phase_t                         phase_reg, phase_next;
    logic [15:0]                    blocks_total_reg, blocks_total_next;
    logic [31:0]                    expected_reg, expected_next;
    logic [15:0]                    block_index_reg, block_index_next;
    logic [SEGMENTS_PER_BLOCK-1:0]  mask_reg, mask_next;
    logic [15:0]                    tick_reg, tick_next;
    logic [31:0]                    crc_reg, crc_next;
    logic [VCNT_W-1:0]              vcount_reg, vcount_next;
    logic [VCNT_W-1:0]              vtarget_reg, vtarget_next;
    logic [23:0]                    rb_word_reg, rb_word_next;
    logic [1:0]                     byte_reg, byte_next;
    logic                           final_reg, final_next;

    // Item fields
    cmd_t        cmd;
    logic [31:0] magic, image_crc;
    logic [15:0] block_count;
    logic [3:0]  segment, block_tag;
    logic [CARRIED_WORDS-1:0][23:0] words;

    logic                           fire, crc_adv;
    logic                           start_ok, seg_ok;
    logic [SEGMENTS_PER_BLOCK-1:0]  seg_dec, mask_set;
    logic [8:0]                     off, rem;
    logic [2:0]                     lat_n;
    logic [15:0]                    word_base, bi1, lim, tick_inc;
    logic [7:0]                     crc_byte_in;
    logic [31:0]                    crc_step;

    // Unpack the input transaction
    always_comb begin
        cmd         = cmd_t'(s_tuser);
        magic       = s_tdata[31:0];
        image_crc   = s_tdata[63:32];
        block_count = s_tdata[79:64];
        segment     = s_tdata[83:80];
        block_tag   = s_tdata[87:84];
        for (int i = 0; i < CARRIED_WORDS; i++) begin
            words[i] = s_tdata[88 + 24*i +: 24];
        end
    end

    // Classify start and segment items
    always_comb begin
        start_ok = (magic == START_MAGIC) && (block_count <= max_blocks_reg);
        seg_ok   = (phase_reg == PH_RECV)
                && (5'(segment) < 5'(SEGMENTS_PER_BLOCK))
                && (block_tag == block_index_reg[3:0]);
        for (int j = 0; j < SEGMENTS_PER_BLOCK; j++) begin
            seg_dec[j] = (segment == 4'(j));
        end
        mask_set  = mask_reg | seg_dec;
        off       = 9'(segment) * 9'(WORDS_PER_SEGMENT);
        rem       = 9'(BLOCK_WORDS) - off;
        if (off >= 9'(BLOCK_WORDS)) begin
            lat_n = 3'd0;
        end else if (rem < 9'(NCARRY)) begin
            lat_n = 3'(rem);
        end else begin
            lat_n = 3'(NCARRY);
        end
        word_base = 16'(block_index_reg * 16'(BLOCK_WORDS)) + 16'(off);
        bi1       = block_index_reg + 16'd1;
        lim       = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
        tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    end

    // Pick the read-back byte and run one CRC step
    always_comb begin
        case (byte_reg)
            2'd0:    crc_byte_in = rb_word_reg[7:0];
            2'd1:    crc_byte_in = rb_word_reg[15:8];
            2'd2:    crc_byte_in = rb_word_reg[23:16];
            default: crc_byte_in = 8'd0;
        endcase
        crc_step = crc32_byte(crc_reg, crc_byte_in);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_ACCEPT: begin
                if (fire && (cmd == CMD_READBACK) && (phase_reg == PH_VERIFY)) begin
                    state_next = FR_CRC;
                end
            end
            FR_CRC: begin
                if (crc_adv && (byte_reg == 2'd3)) begin
                    state_next = FR_ACCEPT;
                end
            end
            default: state_next = FR_ACCEPT;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_tready = 1'b0;
        crc_adv  = 1'b0;
        unique case (state_reg)
            FR_ACCEPT: s_tready = !q_full;
            FR_CRC:    crc_adv  = (byte_reg != 2'd3) || !final_reg || !q_full;
            default:   s_tready = 1'b0;
        endcase
        fire = s_tvalid && s_tready;
    end

    // Session updates and job build
    always_comb begin
        phase_next        = phase_reg;
        blocks_total_next = blocks_total_reg;
        expected_next     = expected_reg;
        block_index_next  = block_index_reg;
        mask_next         = mask_reg;
        tick_next         = tick_reg;
        crc_next          = crc_reg;
        vcount_next       = vcount_reg;
        vtarget_next      = vtarget_reg;
        rb_word_next      = rb_word_reg;
        byte_next         = byte_reg;
        final_next        = final_reg;
        q_push            = 1'b0;
        q_job             = '0;

        if (fire) begin
            case (cmd)
                CMD_START: begin
                    if (start_ok) begin
                        blocks_total_next = block_count;
                        expected_next     = image_crc;
                        vtarget_next      = VCNT_W'(block_count) * VCNT_W'(BLOCK_WORDS);
                        block_index_next  = 16'd0;
                        mask_next         = '0;
                        tick_next         = 16'd0;
                        crc_next          = CRC_INIT;
                        vcount_next       = '0;
                        q_job.erase       = 1'b1;
                        q_push            = 1'b1;
                        if (block_count != 16'd0) begin
                            phase_next    = PH_RECV;
                            q_job.request = 1'b1;
                            q_job.blk     = 16'd0;
                            q_job.miss    = 16'hFFFF;
                        end else begin
                            // empty image: verify passes at once on a zero CRC
                            phase_next   = PH_IDLE;
                            q_job.vstart = 1'b1;
                            q_job.finish = 1'b1;
                            q_job.pass   = (image_crc == 32'd0);
                            q_job.crc    = 32'd0;
                        end
                    end
                end
                CMD_SEGMENT: begin
                    if (seg_ok) begin
                        q_job.lat_n    = lat_n;
                        q_job.lat_addr = app_base_reg + {word_base[14:0], 1'b0};
                        q_job.words    = words;
                        q_push         = (lat_n != 3'd0) || (&mask_set);
                        mask_next      = mask_set;
                        if (&mask_set) begin
                            q_job.commit     = 1'b1;
                            block_index_next = bi1;
                            mask_next        = '0;
                            tick_next        = 16'd0;
                            if (bi1 < blocks_total_reg) begin
                                q_job.request = 1'b1;
                                q_job.blk     = bi1;
                                q_job.miss    = 16'hFFFF;
                            end else begin
                                phase_next   = PH_VERIFY;
                                vcount_next  = '0;
                                crc_next     = CRC_INIT;
                                q_job.vstart = 1'b1;
                                if (blocks_total_reg == 16'd0) begin
                                    phase_next   = PH_IDLE;
                                    q_job.finish = 1'b1;
                                    q_job.pass   = (expected_reg == 32'd0);
                                    q_job.crc    = 32'd0;
                                end
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (phase_reg == PH_RECV) begin
                        tick_next = tick_inc;
                        if (tick_inc >= lim) begin
                            tick_next     = 16'd0;
                            q_push        = 1'b1;
                            q_job.request = 1'b1;
                            q_job.blk     = block_index_reg;
                            q_job.miss    = ~(16'(mask_reg));
                        end
                    end
                end
                default: begin
                    if (phase_reg == PH_VERIFY) begin
                        rb_word_next = words[0];
                        byte_next    = 2'd0;
                        vcount_next  = vcount_reg + VCNT_W'(1);
                        final_next   = ((vcount_reg + VCNT_W'(1)) == vtarget_reg);
                    end
                end
            endcase
        end

        // Fold the latched read-back word into the CRC
        if (crc_adv) begin
            crc_next  = crc_step;
            byte_next = byte_reg + 2'd1;
            if ((byte_reg == 2'd3) && final_reg) begin
                phase_next   = PH_IDLE;
                q_push       = 1'b1;
                q_job.finish = 1'b1;
                q_job.crc    = ~crc_step;
                q_job.pass   = (~crc_step == expected_reg);
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            app_base_reg   <= APP_BASE_RST;
            max_blocks_reg <= MAX_BLOCKS_RST;
            timeout_reg    <= TIMEOUT_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_APP_BASE:      app_base_reg   <= cfg_wr_data;
                CFG_MAX_BLOCKS:    max_blocks_reg <= cfg_wr_data;
                CFG_TIMEOUT_TICKS: timeout_reg    <= cfg_wr_data;
                default:           app_base_reg   <= app_base_reg;
            endcase
        end
    end

    // Session registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= FR_ACCEPT;
            phase_reg        <= PH_IDLE;
            blocks_total_reg <= 16'd0;
            expected_reg     <= 32'd0;
            block_index_reg  <= 16'd0;
            mask_reg         <= '0;
            tick_reg         <= 16'd0;
            crc_reg          <= CRC_INIT;
            vcount_reg       <= '0;
            vtarget_reg      <= '0;
            byte_reg         <= 2'd0;
            final_reg        <= 1'b0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            blocks_total_reg <= blocks_total_next;
            expected_reg     <= expected_next;
            block_index_reg  <= block_index_next;
            mask_reg         <= mask_next;
            tick_reg         <= tick_next;
            crc_reg          <= crc_next;
            vcount_reg       <= vcount_next;
            vtarget_reg      <= vtarget_next;
            byte_reg         <= byte_next;
            final_reg        <= final_next;
        end
    end

    // Read-back word holder
    always_ff @(posedge aclk) begin
        rb_word_reg <= rb_word_next;
    end

endmodule

// ----- rtl/core/siur_queue.sv -----
// ----------------------------------------------------------------------------
// siur_queue
// Two-entry job queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module siur_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  siur_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output siur_pkg::job_t  pop_job
);
    import siur_pkg::*;

    job_t        entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    always_comb begin
        full      = (count_reg == 2'd2);
        pop_valid = (count_reg != 2'd0);
        pop_job   = entry_reg[rd_ptr_reg];
        do_push   = push && !full;
        do_pop    = pop && pop_valid;
        count_next = count_reg + 2'(do_push) - 2'(do_pop);
    end

    // Store a pushed job
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/siur_back.sv -----
// ----------------------------------------------------------------------------
// siur_back
// Result sequencer: presents the results of one job in order, one transaction
// per cycle while m_tready is high, loading the next job as the last is taken.
// ----------------------------------------------------------------------------
module siur_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  siur_pkg::job_t  q_job,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [2:0]      m_tuser,    // kind
    output logic [103:0]    m_tdata,    // address, data, block_number, missing_mask, crc
    output logic            m_tlast
);
    import siur_pkg::*;

    logic        busy_reg;
    logic        erase_reg, commit_reg, req_reg, vstart_reg, finish_reg, pass_reg;
    logic [2:0]  lat_left_reg, lat_idx_reg;
    logic [15:0] addr_reg, blk_reg, miss_reg;
    logic [31:0] crc_reg;
    logic [CARRIED_WORDS-1:0][23:0] words_reg;

    kind_t       kind;
    logic [15:0] o_addr, o_blk, o_miss;
    logic [23:0] o_data;
    logic [31:0] o_crc;
    logic        rest, fire, load;

    // Select the current result and whether more follow
    always_comb begin
        kind   = KIND_LATCH;
        o_addr = 16'd0;
        o_data = 24'd0;
        o_blk  = 16'd0;
        o_miss = 16'd0;
        o_crc  = 32'd0;
        rest   = 1'b0;
        if (erase_reg) begin
            kind = KIND_ERASE;
            rest = (lat_left_reg != 3'd0) || commit_reg || req_reg || vstart_reg || finish_reg;
        end else if (lat_left_reg != 3'd0) begin
            kind   = KIND_LATCH;
            o_addr = addr_reg;
            o_data = words_reg[lat_idx_reg];
            rest   = (lat_left_reg != 3'd1) || commit_reg || req_reg || vstart_reg
                  || finish_reg;
        end else if (commit_reg) begin
            kind = KIND_COMMIT;
            rest = req_reg || vstart_reg || finish_reg;
        end else if (req_reg) begin
            kind   = KIND_REQUEST;
            o_blk  = blk_reg;
            o_miss = miss_reg;
            rest   = vstart_reg || finish_reg;
        end else if (vstart_reg) begin
            kind = KIND_VSTART;
            rest = finish_reg;
        end else begin
            kind  = pass_reg ? KIND_SUCCESS : KIND_FAIL;
            o_crc = crc_reg;
        end

        m_tvalid = busy_reg;
        m_tuser  = kind;
        m_tdata  = {o_crc, o_miss, o_blk, o_data, o_addr};
        m_tlast  = !rest;
        fire     = busy_reg && m_tready;
        load     = q_valid && (!busy_reg || (fire && !rest));
        q_pop    = load;
    end

    // Load a job or retire the result just taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= 1'b1;
        end else if (fire && !rest) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            erase_reg    <= q_job.erase;
            lat_left_reg <= q_job.lat_n;
            lat_idx_reg  <= 3'd0;
            addr_reg     <= q_job.lat_addr;
            words_reg    <= q_job.words;
            commit_reg   <= q_job.commit;
            req_reg      <= q_job.request;
            blk_reg      <= q_job.blk;
            miss_reg     <= q_job.miss;
            vstart_reg   <= q_job.vstart;
            finish_reg   <= q_job.finish;
            pass_reg     <= q_job.pass;
            crc_reg      <= q_job.crc;
        end else if (fire) begin
            if (erase_reg) begin
                erase_reg <= 1'b0;
            end else if (lat_left_reg != 3'd0) begin
                lat_left_reg <= lat_left_reg - 3'd1;
                lat_idx_reg  <= lat_idx_reg + 3'd1;
                addr_reg     <= addr_reg + 16'd2;
            end else if (commit_reg) begin
                commit_reg <= 1'b0;
            end else if (req_reg) begin
                req_reg <= 1'b0;
            end else if (vstart_reg) begin
                vstart_reg <= 1'b0;
            end else begin
                finish_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/segmented_image_update_receiver_core.sv -----
// ----------------------------------------------------------------------------
// segmented_image_update_receiver_core
// Firmware image receiver: start, segment, tick and read-back commands in,
// erase / latch / commit / request / verify results out.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command per transaction (tuser = command). The
//   m_ channel returns the results of each command in order, tuser = kind,
//   tlast on the final result of a command; commands that cause nothing
//   return nothing. Registers are to be written through cfg_wr_* only while
//   idle; the block itself does not enforce this. A command's first result
//   passes the job queue and sequencer registers; a read-back word is
//   folded into the byte-wide CRC unit byte by byte, during which s_tready
//   is low. Throughput: one command per cycle while the two-entry job queue
//   has room and the CRC unit is free, one result per cycle on the m_ side
//   while m_tready is high; a segment that completes a block gives up to
//   eight results. When the receiver stalls, the queue fills and s_tready
//   drops; pending results are held. Reset clears the session to idle and
//   restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module segmented_image_update_receiver_core #(
    parameter int BLOCK_WORDS        = siur_pkg::DEF_BLOCK_WORDS,
    parameter int WORDS_PER_SEGMENT  = siur_pkg::DEF_WORDS_PER_SEGMENT,
    parameter int SEGMENTS_PER_BLOCK = siur_pkg::DEF_SEGMENTS_PER_BLOCK
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_wr_index,
    input  logic [15:0]     cfg_wr_data,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [1:0]      s_tuser,    // command
    input  logic [231:0]    s_tdata,    // magic, image_crc, block_count, segment,
                                        // block_tag, word0 .. word5
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [2:0]      m_tuser,    // kind
    output logic [103:0]    m_tdata,    // address, data, block_number, missing_mask, crc
    output logic            m_tlast
);
    import siur_pkg::*;

    job_t push_job, pop_job;
    logic q_push, q_full, q_pop, q_valid;

    siur_front #(
        .BLOCK_WORDS        (BLOCK_WORDS),
        .WORDS_PER_SEGMENT  (WORDS_PER_SEGMENT),
        .SEGMENTS_PER_BLOCK (SEGMENTS_PER_BLOCK)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    siur_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_job   (pop_job)
    );

    siur_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
